// File: sv/rfpv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfpv_pkg
// Shared codes, reset values, sideband types and helpers for the rigid flow
// projective visibility core.
// ----------------------------------------------------------------------------
package rfpv_pkg;

	localparam int ROWS_DEF      = 256;
	localparam int COLS_DEF      = 512;
	localparam int LABELS_DEF    = 256;
	localparam int FRAC_BITS_DEF = 16;

	// divider: 62-bit magnitude dividend, 31-bit positive divisor
	localparam int DIV_NW = 62;
	localparam int DIV_DW = 31;

	localparam logic [1:0] CMD_POSE  = 2'd0;
	localparam logic [1:0] CMD_DEPTH = 2'd1;
	localparam logic [1:0] CMD_PROC  = 2'd2;

	localparam logic [1:0] ST_MATCH  = 2'd0;
	localparam logic [1:0] ST_BG     = 2'd1;
	localparam logic [1:0] ST_NONE   = 2'd2;
	localparam logic [1:0] ST_NONPOS = 2'd3;

	localparam logic [2:0] CFG_FOCAL_X = 3'd0;
	localparam logic [2:0] CFG_FOCAL_Y = 3'd1;
	localparam logic [2:0] CFG_CENTER_X = 3'd2;
	localparam logic [2:0] CFG_CENTER_Y = 3'd3;
	localparam logic [2:0] CFG_THRESH  = 3'd4;
	localparam logic [2:0] CFG_ROWS    = 3'd5;
	localparam logic [2:0] CFG_COLS    = 3'd6;

	localparam logic [30:0]        FOCAL_RST  = 31'd38600704;
	localparam logic signed [31:0] CX_RST     = 32'sd20971520;
	localparam logic signed [31:0] CY_RST     = 32'sd15728640;
	localparam logic [30:0]        THRESH_RST = 31'd3277;
	localparam logic [8:0]         ROWS_RST   = 9'd240;
	localparam logic [9:0]         COLS_RST   = 10'd320;

	typedef struct packed {
		logic [1:0]        cmd;
		logic              bg;
		logic signed [31:0] cam_x;
		logic signed [31:0] cam_y;
		logic signed [31:0] cam_z;
		logic [16:0]       pix;
		logic [31:0]       lv;
	} rfpv_tag_t;

	typedef struct packed {
		logic               v;
		logic               neg_x;
		logic               neg_y;
		logic               zpos;
		rfpv_tag_t          tag;
		logic signed [31:0] xp;
		logic signed [31:0] yp;
		logic signed [31:0] zp;
	} rfpv_side_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

endpackage
`default_nettype wire

// File: sv/rfpv_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfpv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rfpv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: sv/rfpv_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfpv_div
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// ----------------------------------------------------------------------------
module rfpv_div #(
	parameter int NW = rfpv_pkg::DIV_NW,
	parameter int DW = rfpv_pkg::DIV_DW
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic      [NW-1:0] quo,
	output logic               rem_nz
);
	logic [DW-1:0] rem_s [NW];
	logic [NW-1:0] dq_s  [NW];
	logic [DW-1:0] den_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW-1:0] r_in;
		logic [NW-1:0] q_in;
		logic [DW-1:0] d_in;
		logic [DW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign r_in = '0;
			assign q_in = num;
			assign d_in = den;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign q_in = dq_s[k-1];
			assign d_in = den_s[k-1];
		end

		assign trial = {r_in, q_in[NW-1]};
		assign ge    = trial >= {1'b0, d_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(trial - {1'b0, d_in}) : trial[DW-1:0];
				dq_s[k]  <= {q_in[NW-2:0], ge};
				den_s[k] <= d_in;
			end
		end
	end

	assign quo    = dq_s[NW-1];
	assign rem_nz = |rem_s[NW-1];
endmodule
`default_nettype wire

// File: sv/rigid_flow_projective_visibility_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rigid_flow_projective_visibility_core
// Rigid transform, perspective projection and bilinear depth check of
// labelled points against a loaded depth image; gives visibility and flow.
// ----------------------------------------------------------------------------
// Pipeline: 4 front stages, 62 divider stages and 3 back stages lie between
//   item accept and result valid; the divider gives one quotient bit per stage.
// Throughput: one item per cycle; the whole pipeline holds while a result
//   is stalled at the output.
// Reset: pipeline valids clear and registers take their defaults; pose and
//   depth stores are not cleared.
module rigid_flow_projective_visibility_core #(
	parameter int ROWS      = rfpv_pkg::ROWS_DEF,
	parameter int COLS      = rfpv_pkg::COLS_DEF,
	parameter int LABELS    = rfpv_pkg::LABELS_DEF,
	parameter int FRAC_BITS = rfpv_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic [7:0]         label,
	input  wire logic [3:0]         coef_index,
	input  wire logic [16:0]        pixel_addr,
	input  wire logic signed [31:0] load_value,
	input  wire logic signed [31:0] local_x,
	input  wire logic signed [31:0] local_y,
	input  wire logic signed [31:0] local_z,
	input  wire logic signed [31:0] cam_x,
	input  wire logic signed [31:0] cam_y,
	input  wire logic signed [31:0] cam_z,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    visible,
	output logic signed [31:0]      flow_x,
	output logic signed [31:0]      flow_y,
	output logic signed [31:0]      flow_z,
	output logic [1:0]              status,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);
	import rfpv_pkg::*;

	localparam int LBW = (LABELS > 1) ? $clog2(LABELS) : 1;
	localparam int RW  = $clog2(ROWS);
	localparam int CW  = $clog2(COLS);
	localparam int NPIX = ROWS * COLS;
	localparam int AW  = $clog2(NPIX);

	function automatic logic [2047:0] mod_tab();
		logic [2047:0] t;
		t = '0;
		for (int i = 0; i < 256; i++)
			t[i*8 +: 8] = 8'(i % LABELS);
		return t;
	endfunction

	localparam logic [2047:0] MOD_TAB = mod_tab();

	// configuration
	logic [30:0]        fx_q, fy_q, thr_q;
	logic signed [31:0] cx_q, cy_q;
	logic [8:0]         rows_q;
	logic [9:0]         cols_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fx_q   <= FOCAL_RST;
			fy_q   <= FOCAL_RST;
			cx_q   <= CX_RST;
			cy_q   <= CY_RST;
			thr_q  <= THRESH_RST;
			rows_q <= ROWS_RST;
			cols_q <= COLS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FOCAL_X:  fx_q   <= cfg_data[30:0];
				CFG_FOCAL_Y:  fy_q   <= cfg_data[30:0];
				CFG_CENTER_X: cx_q   <= $signed(cfg_data);
				CFG_CENTER_Y: cy_q   <= $signed(cfg_data);
				CFG_THRESH:   thr_q  <= cfg_data[30:0];
				CFG_ROWS:     rows_q <= cfg_data[8:0];
				CFG_COLS:     cols_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// global advance
	logic adv, acc;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign acc      = in_valid && adv;

	// pose store, one bank per coefficient
	logic [LBW-1:0]     lab_idx;
	logic signed [31:0] ptab [12];

	assign lab_idx = LBW'(MOD_TAB[{label, 3'b000} +: 8]);

	for (genvar k = 0; k < 12; k++) begin : g_pose
		rfpv_ram #(.WIDTH(32), .DEPTH(LABELS)) u_pose (
			.clk   (clk),
			.we    (acc && cmd == CMD_POSE && coef_index == 4'(k)),
			.waddr (lab_idx),
			.wdata (load_value),
			.re    (adv),
			.raddr (lab_idx),
			.rdata (ptab[k])
		);
	end

	// stage 1
	logic               v_s1;
	rfpv_tag_t          tag_s1;
	logic signed [31:0] loc_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1.cmd   <= cmd;
			tag_s1.bg    <= label == 8'd0;
			tag_s1.cam_x <= cam_x;
			tag_s1.cam_y <= cam_y;
			tag_s1.cam_z <= cam_z;
			tag_s1.pix   <= pixel_addr;
			tag_s1.lv    <= load_value;
			loc_s1[0]    <= local_x;
			loc_s1[1]    <= local_y;
			loc_s1[2]    <= local_z;
		end
	end

	// stage 2: products
	logic               v_s2;
	rfpv_tag_t          tag_s2;
	logic signed [63:0] prod_s2 [9];
	logic signed [31:0] off_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2 <= tag_s1;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++)
					prod_s2[r*3+c] <= ptab[r*4+c] * loc_s1[c];
				off_s2[r] <= ptab[r*4+3];
			end
		end
	end

	// stage 3: sum and saturate
	logic               v_s3;
	rfpv_tag_t          tag_s3;
	logic signed [31:0] tp_s3 [3];
	logic signed [63:0] sum [3];

	always_comb begin
		for (int r = 0; r < 3; r++)
			sum[r] = (prod_s2[r*3] >>> FRAC_BITS) + (prod_s2[r*3+1] >>> FRAC_BITS)
			       + (prod_s2[r*3+2] >>> FRAC_BITS) + 64'(off_s2[r]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (adv)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s3 <= tag_s2;
			for (int r = 0; r < 3; r++)
				tp_s3[r] <= sat32(sum[r]);
		end
	end

	// stage 4: magnitudes of the projection numerators
	rfpv_side_t  side_s4;
	logic [61:0] mag_x_s4, mag_y_s4;
	logic [31:0] ax, ay;

	assign ax = tp_s3[0][31] ? 32'(~tp_s3[0] + 32'sd1) : tp_s3[0];
	assign ay = tp_s3[1][31] ? 32'(~tp_s3[1] + 32'sd1) : tp_s3[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			side_s4 <= '0;
		else if (adv) begin
			side_s4.v     <= v_s3;
			side_s4.neg_x <= tp_s3[0][31];
			side_s4.neg_y <= tp_s3[1][31];
			side_s4.zpos  <= !tp_s3[2][31] && (|tp_s3[2]);
			side_s4.tag   <= tag_s3;
			side_s4.xp    <= tp_s3[0];
			side_s4.yp    <= tp_s3[1];
			side_s4.zp    <= tp_s3[2];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_x_s4 <= 62'(ax * fx_q);
			mag_y_s4 <= 62'(ay * fy_q);
		end
	end

	// divider stages
	logic [DIV_NW-1:0] qx, qy;
	logic              rnz_x, rnz_y;
	rfpv_side_t        side_sdiv [DIV_NW];

	rfpv_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_x (
		.clk    (clk),
		.en     (adv),
		.num    (mag_x_s4),
		.den    (side_s4.zp[DIV_DW-1:0]),
		.quo    (qx),
		.rem_nz (rnz_x)
	);

	rfpv_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_y (
		.clk    (clk),
		.en     (adv),
		.num    (mag_y_s4),
		.den    (side_s4.zp[DIV_DW-1:0]),
		.quo    (qy),
		.rem_nz (rnz_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_NW; k++)
				side_sdiv[k] <= '0;
		end else if (adv) begin
			side_sdiv[0] <= side_s4;
			for (int k = 1; k < DIV_NW; k++)
				side_sdiv[k] <= side_sdiv[k-1];
		end
	end

	// stage 5: floor quotient plus principal point
	rfpv_side_t         side_s5;
	logic signed [63:0] col_s5, row_s5;
	logic [63:0]        qxe, qye;

	assign qxe = 64'(qx);
	assign qye = 64'(qy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			side_s5 <= '0;
		else if (adv)
			side_s5 <= side_sdiv[DIV_NW-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s5 <= side_sdiv[DIV_NW-1].neg_x
			        ? 64'(cx_q) + ~qxe + 64'(!rnz_x) : 64'(cx_q) + qxe;
			row_s5 <= side_sdiv[DIV_NW-1].neg_y
			        ? 64'(cy_q) + ~qye + 64'(!rnz_y) : 64'(cy_q) + qye;
		end
	end

	// neighbour ranges, addresses, depth store access
	logic signed [63:0] c1, r1, cp, rp, nr, nc;
	logic               r0ok, r1ok, c0ok, c1ok, fcnz, frnz;
	logic [3:0]         nb_ok;
	logic [AW-1:0]      nb_addr [4];
	logic               dwe;
	logic [31:0]        dep [4];

	always_comb begin
		c1   = col_s5 >>> FRAC_BITS;
		r1   = row_s5 >>> FRAC_BITS;
		cp   = c1 + 64'sd1;
		rp   = r1 + 64'sd1;
		fcnz = |col_s5[FRAC_BITS-1:0];
		frnz = |row_s5[FRAC_BITS-1:0];
		nr   = (32'(rows_q) > 32'(ROWS)) ? 64'(ROWS) : 64'(rows_q);
		nc   = (32'(cols_q) > 32'(COLS)) ? 64'(COLS) : 64'(cols_q);
		r0ok = !r1[63] && r1 < nr;
		r1ok = !rp[63] && rp < nr;
		c0ok = !c1[63] && c1 < nc;
		c1ok = !cp[63] && cp < nc;
		nb_ok[0] = r0ok && c0ok;
		nb_ok[1] = r1ok && c0ok && frnz;
		nb_ok[2] = r0ok && c1ok && fcnz;
		nb_ok[3] = r1ok && c1ok && frnz && fcnz;
		nb_addr[0] = AW'(r1[RW-1:0] * COLS + c1[CW-1:0]);
		nb_addr[1] = AW'(rp[RW-1:0] * COLS + c1[CW-1:0]);
		nb_addr[2] = AW'(r1[RW-1:0] * COLS + cp[CW-1:0]);
		nb_addr[3] = AW'(rp[RW-1:0] * COLS + cp[CW-1:0]);
	end

	assign dwe = adv && side_s5.v && side_s5.tag.cmd == CMD_DEPTH
	          && {15'd0, side_s5.tag.pix} < 32'(NPIX);

	for (genvar k = 0; k < 4; k++) begin : g_depth
		rfpv_ram #(.WIDTH(32), .DEPTH(NPIX)) u_depth (
			.clk   (clk),
			.we    (dwe),
			.waddr (AW'(side_s5.tag.pix)),
			.wdata (side_s5.tag.lv),
			.re    (adv),
			.raddr (nb_addr[k]),
			.rdata (dep[k])
		);
	end

	// stage 6: depth compare
	rfpv_side_t side_s6;
	logic [3:0] nb_ok_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			side_s6 <= '0;
		else if (adv)
			side_s6 <= side_s5;
	end

	always_ff @(posedge clk) begin
		if (adv)
			nb_ok_s6 <= nb_ok;
	end

	logic signed [32:0] dd [4];
	logic [32:0]        ad [4];
	logic               hit;
	logic [1:0]         st;

	always_comb begin
		hit = 1'b0;
		for (int k = 0; k < 4; k++) begin
			dd[k] = 33'(side_s6.zp) - 33'($signed(dep[k]));
			ad[k] = dd[k][32] ? 33'(-dd[k]) : dd[k];
			hit   = hit || (nb_ok_s6[k] && ad[k] < {2'b00, thr_q});
		end
		priority if (side_s6.tag.bg)
			st = ST_BG;
		else if (!side_s6.zpos)
			st = ST_NONPOS;
		else if (hit)
			st = ST_MATCH;
		else
			st = ST_NONE;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv)
			out_valid <= side_s6.v && side_s6.tag.cmd == CMD_PROC;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status  <= st;
			visible <= st == ST_MATCH || st == ST_BG;
			if (st == ST_MATCH) begin
				flow_x <= sat32(64'(side_s6.xp) - 64'(side_s6.tag.cam_x));
				flow_y <= sat32(64'(side_s6.yp) - 64'(side_s6.tag.cam_y));
				flow_z <= sat32(64'(side_s6.zp) - 64'(side_s6.tag.cam_z));
			end else begin
				flow_x <= '0;
				flow_y <= '0;
				flow_z <= '0;
			end
		end
	end
endmodule
`default_nettype wire

// File: sv/rfpv_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfpv_chk
// Port-level checks for the rigid flow projective visibility core.
// ----------------------------------------------------------------------------
module rfpv_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic               visible,
	input wire logic signed [31:0] flow_x,
	input wire logic signed [31:0] flow_y,
	input wire logic signed [31:0] flow_z,
	input wire logic [1:0]         status,
	input wire logic               cfg_ready
);
	import rfpv_pkg::*;

	a_visible: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> visible == (status == ST_MATCH || status == ST_BG))
		else $error("visible disagrees with status");

	a_flow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_MATCH |-> flow_x == 0 && flow_y == 0 && flow_z == 0)
		else $error("flow not zero on unmatched item");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input held without output back-pressure");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(flow_x))
		else $error("stalled item changed");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");
endmodule

bind rigid_flow_projective_visibility_core rfpv_chk u_rfpv_chk (.*);
`default_nettype wire
